FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FFBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("allocator assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define FFBA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

`endif

FILE: rtl/ffba_pkg.sv
// Types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

   localparam int DATA_W    = 32;
   localparam int MIB_W     = 12;
   localparam int SLACK_W   = 16;
   localparam int CSR_DW    = 16;
   localparam int MIB_SHIFT = 20;

   localparam logic [MIB_W-1:0]   MIB_RESET   = 12'd64;
   localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd2048;

   // Register indexes of the configuration port.
   localparam logic CSR_SEGMENT = 1'b0;
   localparam logic CSR_SLACK   = 1'b1;

   // Operation codes of the request word.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Status codes of the response word.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;

   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_USED  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] addr;
      logic [DATA_W-1:0] size;
   } blk_type;

endpackage
`default_nettype wire

FILE: rtl/ffba_if.sv
// Request and response channel interfaces of the allocator.
`default_nettype none
interface ffba_req_if;
   import ffba_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [DATA_W-1:0] req_bytes;
   logic [DATA_W-1:0] free_addr;
   modport source (output valid, op, req_bytes, free_addr, input ready);
   modport sink (input valid, op, req_bytes, free_addr, output ready);
endinterface

interface ffba_rsp_if;
   import ffba_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [DATA_W-1:0] grant_addr;
   logic [DATA_W-1:0] used_bytes;
   logic [DATA_W-1:0] free_bytes;
   modport source (output valid, status, grant_addr, used_bytes, free_bytes, input ready);
   modport sink (input valid, status, grant_addr, used_bytes, free_bytes, output ready);
endinterface
`default_nettype wire

FILE: rtl/first_fit_block_allocator.sv
// Top level: ring of block cells around the allocator sequencer.
// An allocate runs the rounding steps, a scan pass and an update pass; a free runs
// a scan pass, a neighbor pass and an update pass; a failed search ends after the
// first ring pass. Each pass rotates the MAX_BLOCKS-cell ring once past the
// sequencer; one item is in work at a time. A finished response waits in the
// output register while the next request is taken.
// Reset (synchronous) rebuilds a 64 MiB segment with one free block.
`default_nettype none
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 48,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEAD_BYTES   = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ffba_req_if.sink                         req_ch,
   ffba_rsp_if.source                       rsp_ch,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [ffba_pkg::CSR_DW-1:0] csr_wdata
);
   import ffba_pkg::*;

   localparam int RKW = $clog2(MAX_BLOCKS);

   logic              build;
   logic              shift;
   logic [DATA_W-1:0] seg_bytes;
   blk_type           q_blk [MAX_BLOCKS];
   logic [RKW-1:0]    q_rank [MAX_BLOCKS];
   blk_type           tail_blk;
   logic [RKW-1:0]    tail_rank;

   ffba_ctrl #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .HEADER_BYTES(HEADER_BYTES),
      .ALIGN_BYTES (ALIGN_BYTES),
      .HEAD_BYTES  (HEAD_BYTES),
      .RKW         (RKW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .build    (build),
      .seg_bytes(seg_bytes),
      .shift    (shift),
      .head_blk (q_blk[0]),
      .head_rank(q_rank[0]),
      .tail_blk (tail_blk),
      .tail_rank(tail_rank)
   );

   // Ring of cells: each hands its block to the one below, the last takes the tail
   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      blk_type        d_blk;
      logic [RKW-1:0] d_rank;
      if (k == MAX_BLOCKS - 1) begin : g_tail
         assign d_blk  = tail_blk;
         assign d_rank = tail_rank;
      end else begin : g_link
         assign d_blk  = q_blk[k+1];
         assign d_rank = q_rank[k+1];
      end
      ffba_cell #(
         .RKW       (RKW),
         .HEAD_BYTES(HEAD_BYTES),
         .IS_FIRST  (k == 0)
      ) u_cell (
         .clock    (clock),
         .build    (build),
         .seg_bytes(seg_bytes),
         .shift    (shift),
         .d_blk    (d_blk),
         .d_rank   (d_rank),
         .q_blk    (q_blk[k]),
         .q_rank   (q_rank[k])
      );
   end

endmodule
`default_nettype wire

FILE: rtl/ffba_cell.sv
// One block cell of the rotating block ring.
`default_nettype none
module ffba_cell #(
   parameter int RKW        = 6,
   parameter int HEAD_BYTES = 64,
   parameter bit IS_FIRST   = 1'b0
) (
   input  wire logic                        clock,
   input  wire logic                        build,
   input  wire logic [ffba_pkg::DATA_W-1:0] seg_bytes,
   input  wire logic                        shift,
   input  wire ffba_pkg::blk_type           d_blk,
   input  wire logic [RKW-1:0]              d_rank,
   output      ffba_pkg::blk_type           q_blk,
   output      logic [RKW-1:0]              q_rank
);
   import ffba_pkg::*;

   blk_type        blk_ff;
   logic [RKW-1:0] rank_ff;

   // Load the initial segment on build, else take the neighbor's block
   always_ff @(posedge clock) begin
      if (build) begin
         if (IS_FIRST && (seg_bytes > DATA_W'(HEAD_BYTES))) begin
            blk_ff.kind <= KIND_FREE;
            blk_ff.addr <= DATA_W'(HEAD_BYTES);
            blk_ff.size <= seg_bytes - DATA_W'(HEAD_BYTES);
         end else begin
            blk_ff.kind <= KIND_EMPTY;
            blk_ff.addr <= '0;
            blk_ff.size <= '0;
         end
         rank_ff <= '0;
      end else if (shift) begin
         blk_ff  <= d_blk;
         rank_ff <= d_rank;
      end
   end

   assign q_blk  = blk_ff;
   assign q_rank = rank_ff;

endmodule
`default_nettype wire

FILE: rtl/ffba_ctrl.sv
// Sequencer: size rounding, ring scans, ring update and byte counters.
`default_nettype none
`include "assert_macros.svh"
module ffba_ctrl #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 48,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEAD_BYTES   = 64,
   parameter int RKW          = $clog2(MAX_BLOCKS)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ffba_req_if.sink                         req_ch,
   ffba_rsp_if.source                       rsp_ch,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [ffba_pkg::CSR_DW-1:0] csr_wdata,
   output      logic                        build,
   output      logic [ffba_pkg::DATA_W-1:0] seg_bytes,
   output      logic                        shift,
   input  wire ffba_pkg::blk_type           head_blk,
   input  wire logic [RKW-1:0]              head_rank,
   output      ffba_pkg::blk_type           tail_blk,
   output      logic [RKW-1:0]              tail_rank
);
   import ffba_pkg::*;

   localparam int CW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int FW  = $clog2(MAX_BLOCKS + 1);
   localparam int RW  = $clog2(ALIGN_BYTES) + 1;
   localparam int XW  = DATA_W + 1;
   localparam int NW  = DATA_W + 2;
   localparam int LOW_W = 16;
   localparam int YW  = 24;
   localparam int MW  = 31;
   localparam int RSH = 30;
   localparam int FOLD = (65536 % ALIGN_BYTES);
   localparam longint RECIP = (longint'(1) << RSH) / longint'(ALIGN_BYTES) + longint'(1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ROUND = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_NEXT  = 6'b001000,
      ST_UPD   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    step_ff, step_in;
   logic          last;

   logic [MIB_W-1:0]   seg_mib_ff;
   logic [SLACK_W-1:0] slack_ff;
   logic [DATA_W-1:0]  seg_bytes_q;

   logic              op_ff;
   logic [XW-1:0]     x_ff;
   logic [YW-1:0]     y_ff, y_in, q_ff, q_in;
   logic [NW-1:0]     need_ff, need_in;
   logic [DATA_W-1:0] fa_ff;

   // Search results
   logic              hit_ff, hit_in;
   logic              any_empty_ff, any_empty_in;
   logic [RKW-1:0]    best_rank_ff, best_rank_in;
   logic [DATA_W-1:0] best_addr_ff, best_addr_in;
   logic [DATA_W-1:0] best_size_ff, best_size_in;
   logic              placed_ff, placed_in;
   logic              pf_ff, pf_in, nf_ff, nf_in;
   logic [DATA_W-1:0] paddr_ff, paddr_in, psize_ff, psize_in;
   logic [RKW-1:0]    prank_ff, prank_in, nrank_ff, nrank_in;
   logic [DATA_W-1:0] nsize_ff, nsize_in;
   logic [DATA_W-1:0] baddr_ff, baddr_in, bsize_ff, bsize_in;

   logic [DATA_W-1:0] used_ff, free_ff;
   logic [FW-1:0]     fc_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff, status_ff, status_in;
   logic [DATA_W-1:0] rsp_grant_ff, rsp_used_ff, rsp_free_ff;

   logic              split;
   logic              upd_end;
   logic [YW+MW-1:0]  prod;
   logic [YW-1:0]     rem_full;
   logic [RW-1:0]     rem_w;
   logic [DATA_W-1:0] naddr;
   logic [DATA_W-1:0] merged;
   logic [1:0]        nm;
   logic [1:0]        dec;

   assign last    = (cnt_ff == CW'(MAX_BLOCKS - 1));
   assign upd_end = (state_ff == ST_UPD) && last;
   assign naddr   = baddr_ff + bsize_ff;
   assign nm      = {1'b0, nf_ff} + {1'b0, pf_ff};
   assign merged  = bsize_ff + (nf_ff ? nsize_ff : '0);
   assign split   = any_empty_ff &&
                    ({3'b000, best_size_ff} > ({1'b0, need_ff} + {19'd0, slack_ff}));

   // Configuration writes and rebuild of the segment
   assign build     = reset || (csr_wr_en && (csr_index == CSR_SEGMENT));
   assign seg_bytes = reset ? {MIB_RESET, {MIB_SHIFT{1'b0}}}
                            : {csr_wdata[MIB_W-1:0], {MIB_SHIFT{1'b0}}};
   assign seg_bytes_q = {seg_mib_ff, {MIB_SHIFT{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_mib_ff <= MIB_RESET;
         slack_ff   <= SLACK_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SEGMENT: seg_mib_ff <= csr_wdata[MIB_W-1:0];
            CSR_SLACK:   slack_ff   <= csr_wdata[SLACK_W-1:0];
            default:     seg_mib_ff <= seg_mib_ff;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign shift = (state_ff == ST_SCAN) || (state_ff == ST_NEXT) || (state_ff == ST_UPD);

   // Alignment remainder: fold the upper half, then reciprocal multiply
   assign prod     = {{MW{1'b0}}, y_ff} * {{YW{1'b0}}, MW'(RECIP)};
   assign rem_full = y_ff - (q_ff * YW'(ALIGN_BYTES));
   assign rem_w    = rem_full[RW-1:0];

   // Sequencer and search bookkeeping
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      y_in         = y_ff;
      q_in         = q_ff;
      need_in      = need_ff;
      hit_in       = hit_ff;
      any_empty_in = any_empty_ff;
      best_rank_in = best_rank_ff;
      best_addr_in = best_addr_ff;
      best_size_in = best_size_ff;
      placed_in    = placed_ff;
      pf_in        = pf_ff;
      nf_in        = nf_ff;
      paddr_in     = paddr_ff;
      psize_in     = psize_ff;
      prank_in     = prank_ff;
      nrank_in     = nrank_ff;
      nsize_in     = nsize_ff;
      baddr_in     = baddr_ff;
      bsize_in     = bsize_ff;
      status_in    = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               hit_in       = 1'b0;
               any_empty_in = 1'b0;
               placed_in    = 1'b0;
               pf_in        = 1'b0;
               nf_in        = 1'b0;
               step_in      = '0;
               status_in    = ST_OK;
               state_in     = (req_ch.op == OP_ALLOC) ? ST_ROUND : ST_SCAN;
            end
         end
         ST_ROUND: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd0) begin
               y_in = YW'(x_ff[XW-1:LOW_W]) * YW'(FOLD) + YW'(x_ff[LOW_W-1:0]);
            end else if (step_ff == 2'd1) begin
               q_in = prod[RSH+YW-1:RSH];
            end else begin
               need_in  = (rem_w == '0) ? {1'b0, x_ff}
                          : {1'b0, x_ff} + NW'(ALIGN_BYTES) - NW'(rem_w);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_ALLOC) begin
               if (head_blk.kind == KIND_EMPTY) begin
                  any_empty_in = 1'b1;
               end
               if ((head_blk.kind == KIND_FREE) && ({2'b00, head_blk.size} >= need_ff) &&
                   (!hit_ff || (head_rank < best_rank_ff))) begin
                  hit_in       = 1'b1;
                  best_rank_in = head_rank;
                  best_addr_in = head_blk.addr;
                  best_size_in = head_blk.size;
               end
            end else begin
               if ((head_blk.kind == KIND_USED) &&
                   (({1'b0, head_blk.addr} + XW'(HEADER_BYTES)) == {1'b0, fa_ff})) begin
                  hit_in   = 1'b1;
                  baddr_in = head_blk.addr;
                  bsize_in = head_blk.size;
               end
               if ((head_blk.kind == KIND_FREE) &&
                   (({2'b00, head_blk.addr} + {2'b00, head_blk.size} + NW'(HEADER_BYTES))
                    == {2'b00, fa_ff})) begin
                  pf_in    = 1'b1;
                  paddr_in = head_blk.addr;
                  psize_in = head_blk.size;
                  prank_in = head_rank;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               cnt_in = '0;
               if (!hit_in) begin
                  status_in = (op_ff == OP_ALLOC) ? ST_NOFIT : ST_BADFREE;
                  state_in  = ST_DONE;
               end else begin
                  state_in = (op_ff == OP_ALLOC) ? ST_UPD : ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if ((head_blk.kind == KIND_FREE) && (head_blk.addr == naddr)) begin
               nf_in    = 1'b1;
               nsize_in = head_blk.size;
               nrank_in = head_rank;
            end
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if ((op_ff == OP_ALLOC) && split && (head_blk.kind == KIND_EMPTY)) begin
               placed_in = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Rewrite the block leaving the ring head during the update pass
   always_comb begin
      tail_blk  = head_blk;
      tail_rank = head_rank;
      dec       = {1'b0, nf_ff && (head_rank > nrank_ff)} +
                  {1'b0, pf_ff && (head_rank > prank_ff)};
      if (state_ff == ST_UPD) begin
         if (op_ff == OP_ALLOC) begin
            if ((head_blk.kind == KIND_FREE) && (head_rank == best_rank_ff)) begin
               tail_blk.kind = KIND_USED;
               if (split) begin
                  tail_blk.size = need_ff[DATA_W-1:0];
               end
            end else if ((head_blk.kind == KIND_FREE) && (head_rank > best_rank_ff)) begin
               tail_rank = head_rank - 1'b1;
            end else if ((head_blk.kind == KIND_EMPTY) && split && !placed_ff) begin
               tail_blk.kind = KIND_FREE;
               tail_blk.addr = best_addr_ff + need_ff[DATA_W-1:0];
               tail_blk.size = best_size_ff - need_ff[DATA_W-1:0];
               tail_rank     = RKW'(fc_ff - 1'b1);
            end
         end else begin
            if ((head_blk.kind == KIND_USED) && (head_blk.addr == baddr_ff)) begin
               if (pf_ff) begin
                  tail_blk.kind = KIND_EMPTY;
               end else begin
                  tail_blk.kind = KIND_FREE;
                  tail_blk.size = merged;
                  tail_rank     = RKW'(fc_ff - FW'(nm));
               end
            end else if (pf_ff && (head_blk.kind == KIND_FREE) &&
                         (head_blk.addr == paddr_ff)) begin
               tail_blk.size = psize_ff + merged;
               tail_rank     = RKW'(fc_ff - FW'(nm));
            end else if (nf_ff && (head_blk.kind == KIND_FREE) &&
                         (head_blk.addr == naddr)) begin
               tail_blk.kind = KIND_EMPTY;
            end else if (head_blk.kind == KIND_FREE) begin
               tail_rank = head_rank - RKW'(dec);
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Byte counters and free list length
   always_ff @(posedge clock) begin
      if (build) begin
         used_ff <= '0;
         free_ff <= seg_bytes;
         fc_ff   <= (seg_bytes > DATA_W'(HEAD_BYTES)) ? FW'(1) : FW'(0);
      end else if (upd_end) begin
         if (op_ff == OP_ALLOC) begin
            if (split) begin
               used_ff <= used_ff + need_ff[DATA_W-1:0];
               free_ff <= free_ff - need_ff[DATA_W-1:0];
            end else begin
               used_ff <= used_ff + best_size_ff;
               free_ff <= free_ff - best_size_ff;
               fc_ff   <= fc_ff - 1'b1;
            end
         end else begin
            used_ff <= used_ff - bsize_ff;
            free_ff <= free_ff + bsize_ff;
            fc_ff   <= fc_ff + 1'b1 - FW'(nm);
         end
      end
   end

   // Payload and search registers
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_ch.valid) begin
         op_ff <= req_ch.op;
         x_ff  <= {1'b0, req_ch.req_bytes} + XW'(HEADER_BYTES);
         fa_ff <= req_ch.free_addr;
      end
      step_ff      <= step_in;
      y_ff         <= y_in;
      q_ff         <= q_in;
      need_ff      <= need_in;
      hit_ff       <= hit_in;
      any_empty_ff <= any_empty_in;
      best_rank_ff <= best_rank_in;
      best_addr_ff <= best_addr_in;
      best_size_ff <= best_size_in;
      placed_ff    <= placed_in;
      pf_ff        <= pf_in;
      nf_ff        <= nf_in;
      paddr_ff     <= paddr_in;
      psize_ff     <= psize_in;
      prank_ff     <= prank_in;
      nrank_ff     <= nrank_in;
      nsize_ff     <= nsize_in;
      baddr_ff     <= baddr_in;
      bsize_ff     <= bsize_in;
      status_ff    <= status_in;
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_status_ff <= status_ff;
         rsp_grant_ff  <= ((op_ff == OP_ALLOC) && (status_ff == ST_OK))
                          ? best_addr_ff + DATA_W'(HEADER_BYTES) : '0;
         rsp_used_ff   <= used_ff;
         rsp_free_ff   <= free_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.grant_addr = rsp_grant_ff;
   assign rsp_ch.used_bytes = rsp_used_ff;
   assign rsp_ch.free_bytes = rsp_free_ff;

   `FFBA_ASSERT(a_totals_sum, clock, reset, (used_ff + free_ff) == seg_bytes_q)
   `FFBA_ASSERT(a_free_count, clock, reset, fc_ff <= FW'(MAX_BLOCKS))
   `FFBA_ASSERT_IMPL(a_idle_aligned, clock, reset, state_ff == ST_IDLE, cnt_ff == '0)

endmodule
`default_nettype wire

FILE: dv/first_fit_block_allocator_test.sv
// Self-checking testbench of the first-fit block allocator: mirrored block table, directed and random traffic.
`default_nettype none
module first_fit_block_allocator_test;
   import ffba_pkg::*;

   localparam int NBLK      = 64;
   localparam int HDR       = 48;
   localparam int ALIGN     = 8;
   localparam int HEAD      = 64;
   localparam int WDOG_MAX  = 20000;
   localparam int DRAIN     = 250;

   typedef struct {
      logic [1:0]        status;
      logic [DATA_W-1:0] grant;
      logic [DATA_W-1:0] used;
      logic [DATA_W-1:0] free;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_index = CSR_SEGMENT;
   logic [CSR_DW-1:0] csr_wdata = '0;

   ffba_req_if req_ch ();
   ffba_rsp_if rsp_ch ();

   first_fit_block_allocator #(
      .MAX_BLOCKS(NBLK), .HEADER_BYTES(HDR), .ALIGN_BYTES(ALIGN), .HEAD_BYTES(HEAD)
   ) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Mirror of the allocator state
   logic [DATA_W-1:0] blk_addr [NBLK];
   logic [DATA_W-1:0] blk_size [NBLK];
   kind_type          blk_kind [NBLK];
   logic              blk_has_prev [NBLK];
   logic              blk_has_next [NBLK];
   int                blk_prev [NBLK];
   int                blk_next [NBLK];
   int                avail_q [$];
   logic [DATA_W-1:0] used_total, free_total;
   logic [MIB_W-1:0]  seg_mib = MIB_RESET;
   logic [SLACK_W-1:0] slack = SLACK_RESET;

   alloc_result_type  pending_q [$];
   logic [DATA_W-1:0] live_addrs [$];
   logic [DATA_W-1:0] last_freed;
   logic [DATA_W-1:0] last_grant;

   int errors = 0;
   int words_sent = 0;
   int n_granted = 0, n_nofit = 0, n_badfree = 0, n_freed = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   function automatic void rebuild_segment();
      logic [DATA_W-1:0] bytes;
      bytes = DATA_W'(seg_mib) << MIB_SHIFT;
      for (int i = 0; i < NBLK; i++) begin
         blk_addr[i] = '0; blk_size[i] = '0; blk_kind[i] = KIND_EMPTY;
         blk_has_prev[i] = 1'b0; blk_has_next[i] = 1'b0; blk_prev[i] = 0; blk_next[i] = 0;
      end
      avail_q.delete();
      live_addrs.delete();
      used_total = '0;
      free_total = bytes;
      if (bytes > HEAD) begin
         blk_addr[0] = HEAD;
         blk_size[0] = bytes - HEAD;
         blk_kind[0] = KIND_FREE;
         avail_q.push_back(0);
      end
   endfunction

   function automatic void drop_from_avail(int idx);
      foreach (avail_q[p])
         if (avail_q[p] == idx) begin
            avail_q.delete(p);
            return;
         end
   endfunction

   // First-fit search over the free list in insertion order
   function automatic alloc_result_type predict_alloc(logic [DATA_W-1:0] req);
      alloc_result_type r;
      logic [63:0] need;
      int i, n;
      need = (64'(HDR) + 64'(req) + ALIGN - 1) / ALIGN * ALIGN;
      r.status = ST_NOFIT;
      r.grant = '0;
      for (int p = 0; p < avail_q.size(); p++) begin
         i = avail_q[p];
         if (64'(blk_size[i]) < need) continue;
         n = -1;
         if (64'(blk_size[i]) > need + 64'(slack))
            for (int k = 0; k < NBLK; k++)
               if (blk_kind[k] == KIND_EMPTY) begin
                  n = k;
                  break;
               end
         avail_q.delete(p);
         blk_kind[i] = KIND_USED;
         if (n < 0) begin
            used_total += blk_size[i];
            free_total -= blk_size[i];
         end else begin
            // split: remainder goes to the list tail
            blk_addr[n] = blk_addr[i] + DATA_W'(need);
            blk_size[n] = blk_size[i] - DATA_W'(need);
            blk_kind[n] = KIND_FREE;
            blk_has_prev[n] = 1'b1;
            blk_prev[n] = i;
            blk_has_next[n] = blk_has_next[i];
            blk_next[n] = blk_next[i];
            if (blk_has_next[i]) blk_prev[blk_next[i]] = n;
            blk_has_next[i] = 1'b1;
            blk_next[i] = n;
            blk_size[i] = DATA_W'(need);
            if (avail_q.size() < NBLK) avail_q.push_back(n);
            used_total += DATA_W'(need);
            free_total -= DATA_W'(need);
         end
         r.status = ST_OK;
         r.grant = blk_addr[i] + HDR;
         break;
      end
      r.used = used_total;
      r.free = free_total;
      return r;
   endfunction

   // Release a used block and merge with free neighbors, next first
   function automatic alloc_result_type predict_free(logic [DATA_W-1:0] addr);
      alloc_result_type r;
      int cur, t;
      cur = -1;
      r.grant = '0;
      for (int i = 0; i < NBLK; i++)
         if (blk_kind[i] == KIND_USED && 33'(blk_addr[i]) + HDR == 33'(addr)) begin
            cur = i;
            break;
         end
      if (cur < 0) begin
         r.status = ST_BADFREE;
      end else begin
         r.status = ST_OK;
         used_total -= blk_size[cur];
         free_total += blk_size[cur];
         blk_kind[cur] = KIND_FREE;
         if (blk_has_next[cur] && blk_kind[blk_next[cur]] == KIND_FREE) begin
            t = blk_next[cur];
            drop_from_avail(t);
            blk_has_next[cur] = blk_has_next[t];
            blk_next[cur] = blk_next[t];
            if (blk_has_next[t]) blk_prev[blk_next[t]] = cur;
            blk_size[cur] += blk_size[t];
            blk_addr[t] = '0; blk_size[t] = '0; blk_kind[t] = KIND_EMPTY;
            blk_has_prev[t] = 1'b0; blk_has_next[t] = 1'b0; blk_prev[t] = 0; blk_next[t] = 0;
         end
         if (blk_has_prev[cur] && blk_kind[blk_prev[cur]] == KIND_FREE) begin
            t = blk_prev[cur];
            drop_from_avail(t);
            blk_has_next[t] = blk_has_next[cur];
            blk_next[t] = blk_next[cur];
            if (blk_has_next[cur]) blk_prev[blk_next[cur]] = t;
            blk_size[t] += blk_size[cur];
            blk_addr[cur] = '0; blk_size[cur] = '0; blk_kind[cur] = KIND_EMPTY;
            blk_has_prev[cur] = 1'b0; blk_has_next[cur] = 1'b0;
            blk_prev[cur] = 0; blk_next[cur] = 0;
            cur = t;
         end
         if (avail_q.size() < NBLK) avail_q.push_back(cur);
      end
      r.used = used_total;
      r.free = free_total;
      return r;
   endfunction

   // Send one request word; predict it at the edge where it is taken
   task automatic send_word(logic op, logic [DATA_W-1:0] nbytes, logic [DATA_W-1:0] addr);
      alloc_result_type r;
      if ($urandom_range(0, 99) < idle_pct) repeat ($urandom_range(1, 6)) @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.op = op;
      req_ch.req_bytes = nbytes;
      req_ch.free_addr = addr;
      do @(posedge clock); while (!req_ch.ready);
      if (op == OP_ALLOC) begin
         r = predict_alloc(nbytes);
         if (r.status == ST_OK) begin
            live_addrs.push_back(r.grant);
            last_grant = r.grant;
            n_granted++;
         end else n_nofit++;
      end else begin
         r = predict_free(addr);
         if (r.status == ST_OK) begin
            foreach (live_addrs[k])
               if (live_addrs[k] == addr) begin
                  live_addrs.delete(k);
                  break;
               end
            last_freed = addr;
            n_freed++;
         end else n_badfree++;
      end
      pending_q.push_back(r);
      words_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Write a register once the block has gone quiet
   task automatic write_csr(logic idx, logic [CSR_DW-1:0] value);
      while (pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == CSR_SEGMENT) begin
         seg_mib = value[MIB_W-1:0];
         rebuild_segment();
      end else slack = value;
   endtask

   task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("mismatch in %s: got 0x%08h, want 0x%08h", field, got, want);
      errors++;
   endtask

   // Receiver readiness: redrawn every cycle
   always @(negedge clock) rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

   // Compare every response word with the oldest prediction
   always @(posedge clock) begin
      alloc_result_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_q.size() == 0) begin
            $display("response word with no request outstanding");
            errors++;
         end else begin
            w = pending_q.pop_front();
            if (rsp_ch.status !== w.status) report_mismatch("status", rsp_ch.status, w.status);
            if (rsp_ch.grant_addr !== w.grant) report_mismatch("grant_addr", rsp_ch.grant_addr, w.grant);
            if (rsp_ch.used_bytes !== w.used) report_mismatch("used_bytes", rsp_ch.used_bytes, w.used);
            if (rsp_ch.free_bytes !== w.free) report_mismatch("free_bytes", rsp_ch.free_bytes, w.free);
         end
      end
   end

   // Watchdog: count cycles in which no word moves
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
         $display("watchdog expired with %0d responses outstanding", pending_q.size());
         $display("first_fit_block_allocator_test NOT OK");
         $finish;
      end
   end

   task automatic test_directed();
      logic [DATA_W-1:0] a0, a1, a2, a3;
      send_word(OP_ALLOC, 32'd0, '0);            a0 = last_grant;
      send_word(OP_ALLOC, 32'd1, '0);            a1 = last_grant;
      send_word(OP_ALLOC, 32'd8, '0);            a2 = last_grant;
      send_word(OP_ALLOC, 32'd4095, '0);         a3 = last_grant;
      send_word(OP_ALLOC, 32'hFFFF_FFFF, '0);    // oversized request
      send_word(OP_FREE, '0, a1);
      send_word(OP_FREE, '0, a0);                // merges with next
      send_word(OP_FREE, '0, a2);                // merges with previous
      send_word(OP_FREE, '0, a2);                // free of block not in use
      send_word(OP_FREE, '0, 32'd0);
      send_word(OP_FREE, '0, 32'hFFFF_FFFF);
      send_word(OP_FREE, '0, a3);                // back to one block
      send_word(OP_ALLOC, (32'd64 << MIB_SHIFT) - HEAD - HDR, '0);   // exact fit
      send_word(OP_ALLOC, 32'd0, '0);            // nothing left
      send_word(OP_FREE, '0, last_grant);
      send_word(OP_ALLOC, (32'd64 << MIB_SHIFT) - HEAD - HDR - 2000, '0);  // leftover within slack
      send_word(OP_FREE, '0, last_grant);
   endtask

   task automatic test_empty_segment();
      write_csr(CSR_SEGMENT, 16'hF000);          // upper bits dropped: zero MiB
      send_word(OP_ALLOC, 32'd0, '0);
      send_word(OP_FREE, '0, HEAD + HDR);
   endtask

   task automatic test_random_phase(int n_words, int idle, int stall);
      int r;
      logic [DATA_W-1:0] nbytes;
      idle_pct = idle;
      stall_pct = stall;
      repeat (n_words) begin
         r = $urandom_range(0, 99);
         if (r < 50 || live_addrs.size() == 0) begin
            // mostly small sizes so that the table fills and splits run out
            case ($urandom_range(0, 19))
               0: nbytes = $urandom;
               1: nbytes = $urandom_range(0, DATA_W'(seg_mib) << MIB_SHIFT);
               2, 3: nbytes = $urandom_range(0, 65536);
               default: nbytes = $urandom_range(0, 4096);
            endcase
            send_word(OP_ALLOC, nbytes, '0);
         end else if (r < 90) begin
            send_word(OP_FREE, '0, live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
         end else begin
            case ($urandom_range(0, 2))
               0: send_word(OP_FREE, '0, $urandom);
               1: send_word(OP_FREE, '0, last_freed);
               default: send_word(OP_FREE, '0,
                  live_addrs[$urandom_range(0, live_addrs.size() - 1)] + ALIGN);
            endcase
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.op = OP_ALLOC;
      req_ch.req_bytes = '0;
      req_ch.free_addr = '0;
      rsp_ch.ready = 1'b0;
      last_freed = '0;
      last_grant = '0;
      rebuild_segment();
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_empty_segment();
      write_csr(CSR_SEGMENT, 16'd1);
      write_csr(CSR_SLACK, 16'd0);
      test_random_phase(300, 0, 0);
      write_csr(CSR_SEGMENT, 16'h0FFF);
      write_csr(CSR_SLACK, 16'hFFFF);
      test_random_phase(300, 63, 0);
      write_csr(CSR_SEGMENT, 16'd2);
      write_csr(CSR_SLACK, 16'(128 * $urandom_range(0, 16)));
      test_random_phase(300, 0, 63);
      write_csr(CSR_SEGMENT, 16'(MIB_RESET));
      write_csr(CSR_SLACK, 16'(SLACK_RESET));
      test_random_phase(300, 21, 21);

      idle_pct = 0;
      stall_pct = 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("sent %0d request words over four idle and stall mixes and five segment setups",
               words_sent);
      $display("grants %0d, no-fit %0d, releases %0d, bad releases %0d",
               n_granted, n_nofit, n_freed, n_badfree);
      if (errors == 0)
         $display("first_fit_block_allocator_test OK");
      else
         $display("first_fit_block_allocator_test NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
